// ===== hdl/sliding_hamming_distance_defines.svh =====
// Assertion macros used by the checker file of the sliding Hamming distance block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SLIDING_HAMMING_DISTANCE_DEFINES_SVH
`define SLIDING_HAMMING_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/shd_pkg.sv =====
// Package of the sliding Hamming distance block: widths, codes and the cell control struct.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package shd_pkg;

  localparam int SYM_W    = 7;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;
  localparam int DIST_W   = 7;
  localparam int SEEN_W   = 31;

  localparam int MAX_PATTERN_DEF  = 64;
  localparam int SYMBOL_COUNT_DEF = 128;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // Operation codes carried in bit 0 of in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic             load;
    logic             shift;
    logic             clear;
    logic             sym_ok;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
  } shd_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sliding_hamming_distance.sv =====
// Top level of the sliding Hamming distance block: handshakes, length register,
// position counter and output register. Depends on shd_pkg, shd_row and shd_cell.
//
//   channel  direction  contents
//   in_*     slave      tdata: position, symbol; tuser: operation, first_of_text
//   out_*    master     tdata: distance, alignment
//   cfg_*    slave      data: pattern_length
//
// For each text request the whole cell row compares and shifts at once,
// and the result is formed from the updated count of the selected cell.
// The result sits in an output register; a new request is taken while it is
// being delivered, and input stalls only while that register is full and held.
// Synchronous reset clears the match counts, the position counter and the output
// valid, and sets the length register to one.
`timescale 1ns / 1ps
`default_nettype none

module sliding_hamming_distance #(
  parameter int MAX_PATTERN  = shd_pkg::MAX_PATTERN_DEF,
  parameter int SYMBOL_COUNT = shd_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [shd_pkg::IN_DATA_W-1:0]   in_tdata,  // position[5:0], symbol[12:6], zero
  input  wire logic [shd_pkg::IN_USER_W-1:0]   in_tuser,  // operation[0], first_of_text[1]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [shd_pkg::OUT_DATA_W-1:0]  out_tdata, // distance[6:0], alignment[37:7], zero
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [shd_pkg::LEN_W-1:0]       cfg_data   // pattern_length
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [shd_pkg::LEN_W-1:0]   len_r;
  logic [shd_pkg::LEN_W-1:0]   eff_len;
  logic [shd_pkg::LEN_W-1:0]   tap;
  logic [shd_pkg::SEEN_W-1:0]  seen_r;
  logic [shd_pkg::SEEN_W-1:0]  seen_nxt;
  logic                        out_valid_r;
  logic [shd_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [shd_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic [shd_pkg::DIST_W-1:0]  distance;
  logic [shd_pkg::SEEN_W-1:0]  alignment;
  logic [CNT_W-1:0]            tap_cnt;
  logic                        accept;
  logic                        is_text;
  logic                        emit;
  shd_pkg::shd_ctl_t           ctl;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign is_text    = (in_tuser[0] == shd_pkg::OP_TEXT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ctl.load     = accept && (in_tuser[0] == shd_pkg::OP_LOAD);
  assign ctl.shift    = accept && is_text;
  assign ctl.clear    = in_tuser[1];
  assign ctl.position = in_tdata[5:0];
  assign ctl.symbol   = in_tdata[12:6];
  assign ctl.sym_ok   = {2'b00, in_tdata[12:6]} < 9'(SYMBOL_COUNT);

  // Length zero acts as one; a length beyond the row acts as the full row.
  always_comb begin
    if (len_r == '0) begin
      eff_len = shd_pkg::LEN_W'(1);
    end else if (32'(len_r) > MAX_PATTERN) begin
      eff_len = shd_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = len_r;
    end
  end

  assign tap = eff_len - shd_pkg::LEN_W'(1);

  shd_row #(
    .MAX_PATTERN (MAX_PATTERN),
    .CNT_W       (CNT_W)
  ) u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .tap     (tap),
    .tap_cnt (tap_cnt)
  );

  // The text position count saturates at its all-ones value.
  always_comb begin
    if (in_tuser[1]) begin
      seen_nxt = shd_pkg::SEEN_W'(1);
    end else if (seen_r == shd_pkg::SEEN_MAX) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + shd_pkg::SEEN_W'(1);
    end
  end

  assign emit         = is_text && (seen_nxt >= shd_pkg::SEEN_W'(eff_len));
  assign distance     = shd_pkg::DIST_W'(32'(eff_len) - 32'(tap_cnt));
  assign alignment    = seen_nxt - shd_pkg::SEEN_W'(eff_len);
  assign out_data_nxt = {2'b00, alignment, distance};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= shd_pkg::LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (ctl.shift) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/shd_cell.sv =====
// One cell of the comparison row: one pattern symbol and one partial match count.
// Depends on shd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shd_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire shd_pkg::shd_ctl_t     ctl,
  input  wire logic [CNT_W-1:0]      cnt_in,
  output logic      [CNT_W-1:0]      cnt_q,
  output logic      [CNT_W-1:0]      cnt_nxt
);

  logic [shd_pkg::SYM_W-1:0] pat_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      hit;

  assign hit     = ctl.sym_ok && (pat_r == ctl.symbol);
  // A start-of-text request clears the neighbor's count before the shift.
  assign cnt_nxt = (ctl.clear ? '0 : cnt_in) + CNT_W'(hit);
  assign cnt_q   = cnt_r;

  always_ff @(posedge clk) begin
    if (ctl.load && (32'(ctl.position) == INDEX)) begin
      pat_r <= ctl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.shift) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/shd_row.sv =====
// Row of comparison cells chained by their match counts, plus the window tap select.
// Depends on shd_pkg and shd_cell.
`timescale 1ns / 1ps
`default_nettype none

module shd_row #(
  parameter int MAX_PATTERN = shd_pkg::MAX_PATTERN_DEF,
  parameter int CNT_W       = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire shd_pkg::shd_ctl_t          ctl,
  input  wire logic [shd_pkg::LEN_W-1:0]  tap,
  output logic      [CNT_W-1:0]           tap_cnt
);

  logic [CNT_W-1:0] cnt_q   [MAX_PATTERN];
  logic [CNT_W-1:0] cnt_nxt [MAX_PATTERN];
  logic [CNT_W-1:0] cnt_in  [MAX_PATTERN];

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cnt_in[g] = '0;
    end else begin : g_link
      assign cnt_in[g] = cnt_q[g-1];
    end

    shd_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .cnt_in  (cnt_in[g]),
      .cnt_q   (cnt_q[g]),
      .cnt_nxt (cnt_nxt[g])
    );
  end

  // The window result is the updated count of the cell at the window's last position.
  always_comb begin
    tap_cnt = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (32'(tap) == j) begin
        tap_cnt = cnt_nxt[j];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/shd_checker.sv =====
// Port-level checker of the sliding Hamming distance block and its bind to the top level.
// Depends on shd_pkg and sliding_hamming_distance_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_hamming_distance_defines.svh"

module shd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [shd_pkg::IN_USER_W-1:0]   in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [shd_pkg::OUT_DATA_W-1:0]  out_tdata
);

  `SHD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `SHD_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty output")
  `SHD_ASSERT_NEXT(a_load_no_result, in_tvalid && in_tready && (in_tuser[0] == shd_pkg::OP_LOAD), !out_tvalid, "load request produced a result")
  `SHD_ASSERT_NOW(a_distance_range, out_tvalid, out_tdata[6:0] <= 7'd64, "distance beyond window length")

endmodule

bind sliding_hamming_distance shd_checker u_shd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench of sliding_hamming_distance: streams pattern loads and text symbols and checks
// every distance and alignment against an in-bench predictor. Depends on shd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [shd_pkg::DIST_W-1:0] distance;
    logic [shd_pkg::SEEN_W-1:0] alignment;
  } window_result_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [shd_pkg::IN_DATA_W-1:0]  in_tdata   = '0;  // position[5:0], symbol[12:6], zero
  logic [shd_pkg::IN_USER_W-1:0]  in_tuser   = '0;  // operation[0], first_of_text[1]
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [shd_pkg::OUT_DATA_W-1:0] out_tdata;        // distance[6:0], alignment[37:7], zero
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [shd_pkg::LEN_W-1:0]      cfg_data   = '0;  // pattern_length

  // Shadow state of the block.
  logic [shd_pkg::SYM_W-1:0]  pattern_copy [shd_pkg::MAX_PATTERN_DEF];
  logic [shd_pkg::DIST_W-1:0] match_count  [shd_pkg::MAX_PATTERN_DEF];
  logic [shd_pkg::SEEN_W-1:0] text_seen;
  logic [shd_pkg::LEN_W-1:0]  length_reg;

  window_result_t expected_windows[$];
  int mismatches      = 0;
  int items_sent      = 0;
  int send_idle_pct   = 0;
  int ready_stall_pct = 0;

  sliding_hamming_distance u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int window_length(input logic [shd_pkg::LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > shd_pkg::MAX_PATTERN_DEF) return shd_pkg::MAX_PATTERN_DEF;
    return int'(len);
  endfunction

  // Applies one accepted request to the shadow state and queues the window it completes.
  task automatic predict_window(input logic op, input logic [shd_pkg::POS_W-1:0] pos,
                                input logic [shd_pkg::SYM_W-1:0] sym, input logic first);
    int len;
    logic hit;
    window_result_t res;
    if (op == shd_pkg::OP_LOAD) begin
      pattern_copy[pos] = sym;
    end else begin
      if (first) begin
        foreach (match_count[j]) match_count[j] = '0;
        text_seen = '0;
      end
      // The cell row shifts toward higher indexes, so walk it from the top down.
      for (int j = shd_pkg::MAX_PATTERN_DEF - 1; j >= 0; j--) begin
        hit = (sym < shd_pkg::SYMBOL_COUNT_DEF) && (pattern_copy[j] == sym);
        match_count[j] = ((j > 0) ? match_count[j-1] : shd_pkg::DIST_W'(0)) +
                         shd_pkg::DIST_W'(hit);
      end
      if (text_seen != shd_pkg::SEEN_MAX) text_seen++;
      len = window_length(length_reg);
      if (text_seen >= shd_pkg::SEEN_W'(len)) begin
        res.distance  = shd_pkg::DIST_W'(len - int'(match_count[len-1]));
        res.alignment = text_seen - shd_pkg::SEEN_W'(len);
        expected_windows.insert(expected_windows.size(), res);
      end
    end
  endtask

  task automatic send_item(input logic op, input logic [shd_pkg::POS_W-1:0] pos,
                           input logic [shd_pkg::SYM_W-1:0] sym, input logic first);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {3'b000, sym, pos};
    in_tuser  = {first, op};
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_window(op, pos, sym, first);
    items_sent++;
  endtask

  // Loads and short texts leave no result behind, so keep waiting after the expected queue empties.
  task automatic drain_results;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [shd_pkg::LEN_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    length_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= ready_stall_pct);
  end

  always @(posedge clk) begin : check_results
    window_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_windows.size() == 0) begin
        $display("%0t: result with none expected: distance %0d alignment %0d", $time,
                 out_tdata[shd_pkg::DIST_W-1:0],
                 out_tdata[shd_pkg::DIST_W+shd_pkg::SEEN_W-1:shd_pkg::DIST_W]);
        mismatches++;
      end else begin
        want = expected_windows.pop_front();
        if (out_tdata[shd_pkg::DIST_W-1:0] !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                   out_tdata[shd_pkg::DIST_W-1:0]);
          mismatches++;
        end
        if (out_tdata[shd_pkg::DIST_W+shd_pkg::SEEN_W-1:shd_pkg::DIST_W] !== want.alignment)
        begin
          $display("%0t: alignment expected %0d actual %0d", $time, want.alignment,
                   out_tdata[shd_pkg::DIST_W+shd_pkg::SEEN_W-1:shd_pkg::DIST_W]);
          mismatches++;
        end
      end
    end
  end

  // Every entry is written before any text arrives; the ends carry symbols 0 and 127.
  task automatic test_pattern_load;
    for (int i = 0; i < shd_pkg::MAX_PATTERN_DEF - 1; i++) begin
      send_item(shd_pkg::OP_LOAD, shd_pkg::POS_W'(i), shd_pkg::SYM_W'(i), i[0]);
    end
    send_item(shd_pkg::OP_LOAD, shd_pkg::POS_W'(shd_pkg::MAX_PATTERN_DEF - 1), 7'd127, 1'b1);
  endtask

  // Reset length of one, then a length of zero, which must act as one.
  task automatic test_single_symbol_window;
    send_item(shd_pkg::OP_TEXT, 6'd63, 7'd0, 1'b1);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd127, 1'b0);
    send_item(shd_pkg::OP_TEXT, 6'd5, 7'd0, 1'b1);
    write_length(7'd0);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd0, 1'b0);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd64, 1'b0);
  endtask

  // Too few symbols after a start-of-text mark, a restart in mid-text, a pattern change
  // in mid-text, and a length change without a new text.
  task automatic test_short_window;
    write_length(7'd3);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd0, 1'b1);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd1, 1'b0);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd2, 1'b0);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd5, 1'b0);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd0, 1'b1);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd1, 1'b0);
    send_item(shd_pkg::OP_LOAD, 6'd2, 7'd9, 1'b0);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd9, 1'b0);
    write_length(7'd2);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd1, 1'b0);
    send_item(shd_pkg::OP_LOAD, 6'd2, 7'd2, 1'b1);
  endtask

  // A length above the row size acts as the full row; an all-miss window gives 64.
  task automatic test_full_window;
    write_length(7'd127);
    for (int i = 0; i < shd_pkg::MAX_PATTERN_DEF; i++) begin
      send_item(shd_pkg::OP_TEXT, 6'd0, 7'd100, i == 0);
    end
    write_length(7'd65);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd0, 1'b0);
    write_length(7'd64);
    send_item(shd_pkg::OP_TEXT, 6'd0, 7'd127, 1'b0);
  endtask

  function automatic logic [shd_pkg::LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return shd_pkg::LEN_W'($urandom_range(60, 68));
      default: return shd_pkg::LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Texts mostly follow the stored pattern so that distances spread over the whole range.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int quota);
    int stop_at;
    int len;
    int burst;
    int loads;
    logic [shd_pkg::SYM_W-1:0] sym;
    stop_at         = items_sent + quota;
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 3) write_length(pick_length());
      loads = ($urandom_range(9) < 4) ? $urandom_range(1, 4) : 0;
      repeat (loads) begin
        send_item(shd_pkg::OP_LOAD, shd_pkg::POS_W'($urandom), shd_pkg::SYM_W'($urandom),
                  1'($urandom));
      end
      len   = window_length(length_reg);
      burst = $urandom_range(1, 2 * len + 4);
      for (int t = 0; t < burst; t++) begin
        if ($urandom_range(99) < 4) begin
          send_item(shd_pkg::OP_LOAD, shd_pkg::POS_W'($urandom), shd_pkg::SYM_W'($urandom),
                    1'($urandom));
        end
        sym = ($urandom_range(9) < 7) ? pattern_copy[t % len] : shd_pkg::SYM_W'($urandom);
        send_item(shd_pkg::OP_TEXT, shd_pkg::POS_W'($urandom), sym,
                  (t == 0) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 3));
      end
    end
  endtask

  initial begin
    foreach (pattern_copy[i]) pattern_copy[i] = '0;
    foreach (match_count[i]) match_count[i] = '0;
    text_seen  = '0;
    length_reg = 7'd1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_pattern_load();
    test_single_symbol_window();
    test_short_window();
    test_full_window();
    test_random_traffic(0, 0, 170);
    test_random_traffic(54, 0, 160);
    test_random_traffic(0, 54, 160);
    test_random_traffic(14, 14, 160);
    test_random_traffic(0, 0, 150);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
